/* rtl/core/cbsc_pkg.sv */
// Shared types and codes for the change-or-block sample capture block.
// No dependencies; every module of the block imports this package.
package cbsc_pkg;

    // Item codes carried in the mode field
    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_FLUSH   = 2'd1;
    localparam logic [1:0] MODE_DISCARD = 2'd2;

    // Register indexes, taken from paddr[2]
    localparam logic REG_BLOCK_SIZE = 1'b0;
    localparam logic REG_HOLDOFF    = 1'b1;

    localparam logic [15:0] HOLDOFF_RESET = 16'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] sample;
    } cbsc_in_t;

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  position;
        logic        is_event;
        logic        overflowed;
        logic        last;
    } cbsc_out_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [6:0] held_count;  // wide enough for any buffer depth in range
        logic       flush_ok;    // threshold met and buffer not empty
        logic       out_free;    // output register empty or being taken
    } cbsc_sts_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       do_sample;
        logic       do_clear;
        logic       latch_flush;
        logic       load_out;
        logic [5:0] rd_idx;
        logic       rd_last;
    } cbsc_ctl_t;

endpackage

/* rtl/core/cbsc_regs.sv */
// APB-style configuration registers: block_size and holdoff.
// Depends on cbsc_pkg for register indexes and reset values.
module cbsc_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [5:0]  block_size,
    output logic [15:0] holdoff
);
    import cbsc_pkg::*;

    logic [5:0]  block_size_reg;
    logic [15:0] holdoff_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= '0;
            holdoff_reg    <= HOLDOFF_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_BLOCK_SIZE: block_size_reg <= pwdata[5:0];
                REG_HOLDOFF:    holdoff_reg    <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BLOCK_SIZE: prdata = 32'(block_size_reg);
            REG_HOLDOFF:    prdata = 32'(holdoff_reg);
            default:        prdata = '0;
        endcase
    end

    assign block_size = block_size_reg;
    assign holdoff    = holdoff_reg;

endmodule

/* rtl/core/cbsc_datapath.sv */
// Datapath: sample store, last-kept slot, counters, hold-off and output register.
// Depends on cbsc_pkg for the command, status and result types.
module cbsc_datapath #(
    parameter int BUFFER_DEPTH = 32,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [5:0]          block_size,
    input  logic [15:0]         holdoff,
    input  logic [31:0]         sample,
    input  cbsc_pkg::cbsc_ctl_t ctl,
    output cbsc_pkg::cbsc_sts_t sts,
    output cbsc_pkg::cbsc_out_t rec,
    output logic                rec_valid,
    input  logic                rec_ready
);
    import cbsc_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];

    logic [SAMPLE_BITS-1:0] slot0_reg, slot0_next;
    logic [CW-1:0]          held_count_reg, held_count_next;
    logic [15:0]            holdoff_left_reg, holdoff_left_next;
    logic                   dropped_reg, dropped_next;
    logic                   tag_event_reg, tag_drop_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_value_reg;
    logic [AW-1:0]          out_pos_reg;
    logic                   out_last_reg;
    logic                   out_event_reg;
    logic                   out_drop_reg;

    logic [SAMPLE_BITS-1:0] s_in;
    logic [7:0]             held_w;
    logic [7:0]             bs_w;
    logic [15:0]            hl_dec;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   event_mode;

    assign s_in       = SAMPLE_BITS'(sample);
    assign held_w     = 8'(held_count_reg);
    assign bs_w       = 8'(block_size);
    assign hl_dec     = holdoff_left_reg - 16'd1;
    assign event_mode = (block_size == 6'd0);
    assign rd_addr    = AW'(ctl.rd_idx);

    always_comb
    begin
        slot0_next        = slot0_reg;
        held_count_next   = held_count_reg;
        holdoff_left_next = holdoff_left_reg;
        dropped_next      = dropped_reg;
        wr_en             = 1'b0;
        wr_addr           = held_count_reg[AW-1:0];

        if (ctl.do_sample)
        begin
            if (event_mode)
            begin
                if (holdoff_left_reg != 16'd0)
                    holdoff_left_next = hl_dec;
                // countdown still running or value unchanged: refuse
                if (!(holdoff_left_reg != 16'd0 && hl_dec != 16'd0) &&
                    (s_in != slot0_reg))
                begin
                    holdoff_left_next = holdoff;
                    slot0_next        = s_in;
                    held_count_next   = CW'(1);
                    wr_en             = 1'b1;
                    wr_addr           = '0;
                end
            end
            else if (held_w < bs_w && held_w < 8'(BUFFER_DEPTH))
            begin
                wr_en           = 1'b1;
                held_count_next = held_count_reg + CW'(1);
                if (held_count_reg == '0)
                    slot0_next = s_in;
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (ctl.do_clear)
        begin
            held_count_next = '0;
            dropped_next    = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load_out)
            out_valid_next = 1'b1;
        else if (rec_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_reg        <= '0;
            held_count_reg   <= '0;
            holdoff_left_reg <= '0;
            dropped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            slot0_reg        <= slot0_next;
            held_count_reg   <= held_count_next;
            holdoff_left_reg <= holdoff_left_next;
            dropped_reg      <= dropped_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // store and result payload, no reset; flags travel with each result so a
    // waiting result keeps them when the next flush is taken
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= s_in;
        if (ctl.latch_flush)
        begin
            tag_event_reg <= event_mode;
            tag_drop_reg  <= dropped_reg;
        end
        if (ctl.load_out)
        begin
            out_value_reg <= mem[rd_addr];
            out_pos_reg   <= rd_addr;
            out_last_reg  <= ctl.rd_last;
            out_event_reg <= tag_event_reg;
            out_drop_reg  <= tag_drop_reg;
        end
    end

    assign sts.held_count = 7'(held_count_reg);
    assign sts.flush_ok   = (held_w >= bs_w) && (held_count_reg != '0);
    assign sts.out_free   = !out_valid_reg || rec_ready;

    assign rec_valid      = out_valid_reg;
    assign rec.value      = 32'(out_value_reg);
    assign rec.position   = 5'(out_pos_reg);
    assign rec.is_event   = out_event_reg;
    assign rec.overflowed = out_drop_reg;
    assign rec.last       = out_last_reg;

endmodule

/* rtl/core/cbsc_ctrl.sv */
// Controller: takes items, decodes mode and sequences the flush readout.
// Depends on cbsc_pkg for mode codes and the command and status types.
module cbsc_ctrl #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [1:0]          mode,
    input  cbsc_pkg::cbsc_sts_t sts,
    output cbsc_pkg::cbsc_ctl_t ctl
);
    import cbsc_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_FLUSH
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          accept;
    logic          last_one;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign last_one  = (CW'(idx_reg) + CW'(1)) == cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        ctl.do_sample   = 1'b0;
        ctl.do_clear    = 1'b0;
        ctl.latch_flush = 1'b0;
        ctl.load_out    = 1'b0;
        ctl.rd_idx      = 6'(idx_reg);
        ctl.rd_last     = last_one;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_SAMPLE:  ctl.do_sample = 1'b1;
                        MODE_FLUSH:
                        begin
                            ctl.do_clear = 1'b1;
                            if (sts.flush_ok)
                            begin
                                ctl.latch_flush = 1'b1;
                                cnt_next        = sts.held_count[CW-1:0];
                                idx_next        = '0;
                                state_next      = S_FLUSH;
                            end
                        end
                        MODE_DISCARD: ctl.do_clear = 1'b1;
                        default:      ;
                    endcase
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    idx_next     = idx_reg + AW'(1);
                    if (last_one)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/core/change_or_block_sample_capture_top.sv */
// Top level of the change-or-block sample capture block.
// Depends on cbsc_pkg, cbsc_regs, cbsc_ctrl and cbsc_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  cmd      | cmd_valid/cmd_ready  | cbsc_in_t  {mode, sample}
//  rec      | rec_valid/rec_ready  | cbsc_out_t {value, position, is_event,
//           |                      |             overflowed, last}
//  apb      | psel/penable/pready  | paddr[2:0], pwdata, prdata (32 bits)
//
// Sample, discard and unused-mode items do not leave idle; cmd_ready stays
// high while the last result still sits in the output register.
// A flush that emits results holds cmd_ready low until its last one is
// loaded: the readout walks the store one entry a cycle through its single
// read port, and waits whenever rec_ready is low and a result is held.
// Reset is asynchronous and active low; it clears the last-kept slot, counts
// and flags at once, so no clearing pass is needed.
// Registers: block_size at 0x0, holdoff at 0x4; write only while idle.
module change_or_block_sample_capture_top #(
    parameter int BUFFER_DEPTH = 32,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cbsc_pkg::cbsc_in_t  cmd,

    output logic                rec_valid,
    input  logic                rec_ready,
    output cbsc_pkg::cbsc_out_t rec
);
    import cbsc_pkg::*;

    logic [5:0]  block_size;
    logic [15:0] holdoff;
    cbsc_ctl_t   ctl;
    cbsc_sts_t   sts;

    // configuration registers
    cbsc_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .block_size (block_size),
        .holdoff    (holdoff)
    );

    // item decode and flush sequencing
    cbsc_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .mode      (cmd.mode),
        .sts       (sts),
        .ctl       (ctl)
    );

    // store, hold-off, counts and output register
    cbsc_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .block_size (block_size),
        .holdoff    (holdoff),
        .sample     (cmd.sample),
        .ctl        (ctl),
        .sts        (sts),
        .rec        (rec),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready)
    );

endmodule
